/* rtl/cct_pkg.sv */
package cct_pkg;

	localparam int TableDepth = 32;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int KeyW = 32;
	localparam int MaxResults = 32;
	localparam logic [15:0] TimeoutReset = 16'd10;
	localparam logic [15:0] CountMax = 16'hFFFF;

	localparam logic [1:0] CMD_CONNECT = 2'd0;
	localparam logic [1:0] CMD_DISCONNECT = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_DISC = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;
	localparam logic [1:0] KIND_SHUT = 2'd3;

	localparam logic [1:0] RPT_NONE = 2'd0;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [31:0] last_active;
		logic [15:0] open_count;
		logic logged;
		logic [1:0] report;
	} entry_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] addr;
		logic newc;
		logic full;
		logic last;
	} result_t;

endpackage

/* rtl/client_connection_tracker_unit.sv */
// Client connection tracker.
// s_axis carries one request: tuser = cmd (connect, disconnect, one-second
// tick, shutdown flush), tdata = client address. m_axis carries reports:
// tuser = kind, tdata = address, new_connection, table_full; tlast marks the
// final report of a request. A request with nothing to report (tick with
// nothing due, disconnect of an unknown or idle client) gives no output.
// One request at a time. The 32-entry table sits in a synchronous memory and
// each entry visit has a read step and a check step. s_axis_tready comes back
// once the request is finished; a connect to an unknown client scans the
// table twice, first to search and then to sweep out expired idle clients,
// with a read and a write step per removed entry, before it inserts it.
// Reports do not slow the scan while m_axis keeps up; one sits in the output
// register and the next is held back until it is known whether it is the
// last. While m_axis_tready stays low the scan waits at the next report.
// Reset empties the table, clears the second counter and sets idle_timeout
// to 10. Configuration: APB, idle_timeout at address 0.
module client_connection_tracker_unit import cct_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // client_addr
	input logic [1:0] s_axis_tuser, // cmd
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // client_addr_out, new_connection, table_full
	output logic [1:0] m_axis_tuser, // kind
	output logic m_axis_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [15:0] idle_timeout_q;
	logic we;
	logic [IdxW-1:0] waddr, raddr;
	entry_t wdata, rdata;
	result_t res;
	logic cfg_hit;

	assign pready = 1'b1;
	assign cfg_hit = paddr == 2'd0;
	assign prdata = cfg_hit ? {16'd0, idle_timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= TimeoutReset;
		end else if (psel && penable && pwrite && cfg_hit) begin
			idle_timeout_q <= pwdata[15:0];
		end
	end

	cct_table u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	cct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .idle_timeout(idle_timeout_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cmd(s_axis_tuser), .client_addr(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res),
		.we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign m_axis_tdata = {6'd0, res.full, res.newc, res.addr};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

/* rtl/cct_table.sv */
module cct_table import cct_pkg::*; (
	input logic clk,
	input logic we,
	input logic [IdxW-1:0] waddr,
	input entry_t wdata,
	input logic [IdxW-1:0] raddr,
	output entry_t rdata
);

	entry_t mem [TableDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/cct_ctrl.sv */
module cct_ctrl import cct_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [15:0] idle_timeout,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [31:0] client_addr,
	output logic out_valid,
	input logic out_ready,
	output result_t out_res,
	output logic we,
	output logic [IdxW-1:0] waddr,
	output entry_t wdata,
	output logic [IdxW-1:0] raddr,
	input entry_t rdata
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_RD    = 8'b00000010,
		ST_CHK   = 8'b00000100,
		ST_MVRD  = 8'b00001000,
		ST_MVWR  = 8'b00010000,
		ST_FIN   = 8'b00100000,
		ST_EMIT  = 8'b01000000,
		ST_FINRD = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] cmd_q;
	logic [KeyW-1:0] key_q;
	logic [CntW-1:0] count_q, count_d, idx_q, idx_d;
	logic [31:0] now_q, now_d;
	logic [5:0] nres_q, nres_d;
	logic found_q, found_d, sweep_q, sweep_d;
	logic [IdxW-1:0] hit_q, hit_d;
	result_t pend_q, pend_d;
	logic pend_valid_q, pend_valid_d;
	result_t res_q, res_d;
	logic res_valid_q, res_valid_d;

	logic [31:0] age;
	logic idle;
	logic [CntW-1:0] lastix;
	logic out_free;
	logic blocked;
	logic push;
	result_t rpt;

	assign age = now_q - rdata.last_active;
	assign idle = rdata.open_count == 16'd0;
	assign lastix = count_q - CntW'(1);
	// a new report needs the held-back one moved to the output register first
	assign out_free = !res_valid_q || out_ready;
	assign blocked = pend_valid_q && !out_free;

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = res_valid_q;
	assign out_res = res_q;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		now_d = now_q;
		idx_d = idx_q;
		nres_d = nres_q;
		found_d = found_q;
		sweep_d = sweep_q;
		hit_d = hit_q;
		pend_d = pend_q;
		pend_valid_d = pend_valid_q;
		res_d = res_q;
		res_valid_d = res_valid_q && !out_ready;
		rpt = '0;
		push = 1'b0;
		we = 1'b0;
		waddr = idx_q[IdxW-1:0];
		wdata = rdata;
		raddr = idx_q[IdxW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					idx_d = '0;
					nres_d = '0;
					found_d = 1'b0;
					sweep_d = 1'b0;
					if (cmd == CMD_TICK) now_d = now_q + 32'd1;
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				if (idx_q >= count_q) state_d = ST_FIN;
				else state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = ST_RD;
				idx_d = idx_q + CntW'(1);
				if (!sweep_q) begin
					case (cmd_q)
						CMD_TICK: begin
							if (idle && rdata.report == RPT_NONE &&
								age >= {16'd0, idle_timeout}) begin
								rpt.kind = KIND_TIMEOUT;
								push = 1'b1;
							end
						end
						CMD_FLUSH: begin
							if (!idle) begin
								rpt.kind = KIND_SHUT;
								push = 1'b1;
							end else if (rdata.report == RPT_NONE) begin
								rpt.kind = KIND_TIMEOUT;
								push = 1'b1;
							end
						end
						default: begin
							if (rdata.key == key_q) begin
								found_d = 1'b1;
								hit_d = idx_q[IdxW-1:0];
								state_d = ST_FIN;
							end
						end
					endcase
					if (push) begin
						rpt.addr = rdata.key;
						if (blocked) begin
							push = 1'b0;
							idx_d = idx_q;
							state_d = ST_CHK;
						end else begin
							we = 1'b1;
							wdata.report = rpt.kind;
							nres_d = nres_q + 6'd1;
							if (nres_q == 6'(MaxResults - 1)) state_d = ST_EMIT;
						end
					end
				end else if (idle && age > {16'd0, idle_timeout}) begin
					idx_d = idx_q;
					state_d = ST_MVRD;
					if (rdata.report == RPT_NONE) begin
						if (nres_q >= 6'(MaxResults - 1)) begin
							// budget spent: the rest waits for a later sweep
							state_d = ST_FIN;
						end else if (blocked) begin
							state_d = ST_CHK;
						end else begin
							rpt.kind = KIND_TIMEOUT;
							rpt.addr = rdata.key;
							push = 1'b1;
							nres_d = nres_q + 6'd1;
						end
					end
				end
			end
			ST_MVRD: begin
				// swap-remove: last entry moves into the swept slot
				raddr = lastix[IdxW-1:0];
				state_d = ST_MVWR;
			end
			ST_MVWR: begin
				if (idx_q != lastix) begin
					we = 1'b1;
					waddr = idx_q[IdxW-1:0];
					wdata = rdata;
				end
				count_d = lastix;
				state_d = ST_RD;
			end
			ST_FIN: begin
				raddr = hit_q;
				state_d = ST_EMIT;
				if (cmd_q == CMD_CONNECT) begin
					if (found_q) begin
						state_d = ST_FINRD;
					end else if (!sweep_q) begin
						sweep_d = 1'b1;
						idx_d = '0;
						state_d = ST_RD;
					end else if (blocked) begin
						state_d = ST_FIN;
					end else begin
						rpt.kind = KIND_REPLY;
						rpt.addr = key_q;
						push = 1'b1;
						if (count_q >= CntW'(TableDepth)) begin
							rpt.full = 1'b1;
						end else begin
							we = 1'b1;
							waddr = count_q[IdxW-1:0];
							wdata = '{key_q, now_q, 16'd1, 1'b1, RPT_NONE};
							count_d = count_q + CntW'(1);
							rpt.newc = 1'b1;
						end
					end
				end else if (cmd_q == CMD_DISCONNECT && found_q) begin
					state_d = ST_FINRD;
				end
			end
			ST_FINRD: begin
				raddr = hit_q;
				waddr = hit_q;
				state_d = ST_EMIT;
				if (cmd_q == CMD_CONNECT) begin
					we = 1'b1;
					wdata.last_active = now_q;
					wdata.logged = 1'b1;
					if (idle) begin
						wdata.report = RPT_NONE;
						wdata.open_count = 16'd1;
					end else if (rdata.open_count != CountMax) begin
						wdata.open_count = rdata.open_count + 16'd1;
					end
					rpt.kind = KIND_REPLY;
					rpt.addr = key_q;
					rpt.newc = idle | ~rdata.logged;
					push = 1'b1;
				end else if (!idle) begin
					we = 1'b1;
					wdata.last_active = now_q;
					wdata.open_count = rdata.open_count - 16'd1;
					if (rdata.open_count == 16'd1 && rdata.report == RPT_NONE) begin
						wdata.report = KIND_DISC;
						rpt.kind = KIND_DISC;
						rpt.addr = key_q;
						push = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				// the held-back report is the final one of this request
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					res_d = pend_q;
					res_d.last = 1'b1;
					res_valid_d = 1'b1;
					pend_valid_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (push) begin
			if (pend_valid_q) begin
				res_d = pend_q;
				res_valid_d = 1'b1;
			end
			pend_d = rpt;
			pend_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			now_q <= '0;
			idx_q <= '0;
			nres_q <= '0;
			found_q <= 1'b0;
			sweep_q <= 1'b0;
			hit_q <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			now_q <= now_d;
			idx_q <= idx_d;
			nres_q <= nres_d;
			found_q <= found_d;
			sweep_q <= sweep_d;
			hit_q <= hit_d;
			pend_valid_q <= pend_valid_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= cmd;
			key_q <= client_addr;
		end
		pend_q <= pend_d;
		res_q <= res_d;
	end

endmodule

/* verif/tb.sv */
module tb;
	import cct_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0; // client_addr
	logic [1:0] s_axis_tuser = '0; // cmd
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata; // addr[31:0], new_connection[32], table_full[33]
	logic [1:0] m_axis_tuser; // kind
	logic m_axis_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	client_connection_tracker_unit u_dut (.*);

	always #4 clk = ~clk;

	// tracker mirror
	entry_t tbl[TableDepth];
	int n_entries;
	logic [31:0] now_sec;
	logic [15:0] timeout_sec;
	result_t expected_reports[$];
	int mismatches;
	int src_idle_pct, snk_idle_pct;
	bit hold_sink;

	function automatic void push_report(logic [1:0] k, logic [31:0] a, logic nc, logic fl);
		result_t r;
		r.kind = k; r.addr = a; r.newc = nc; r.full = fl; r.last = 1'b0;
		expected_reports.push_back(r);
	endfunction

	function automatic int find_client(logic [31:0] a);
		for (int i = 0; i < n_entries; i++)
			if (tbl[i].key == a) return i;
		return -1;
	endfunction

	function automatic void track_request(logic [1:0] cmd, logic [31:0] a);
		int n, idx, i, base;
		logic nc;
		n = 0;
		base = expected_reports.size();
		case (cmd)
			CMD_CONNECT: begin
				idx = find_client(a);
				nc = 1'b0;
				if (idx < 0) begin
					i = 0;
					while (i < n_entries) begin
						if (tbl[i].open_count == 0 &&
							(now_sec - tbl[i].last_active) > {16'd0, timeout_sec}) begin
							if (tbl[i].report == RPT_NONE) begin
								if (n >= MaxResults - 1) break;
								tbl[i].report = KIND_TIMEOUT;
								push_report(KIND_TIMEOUT, tbl[i].key, 0, 0); n++;
							end
							if (i < n_entries - 1) tbl[i] = tbl[n_entries-1];
							n_entries--;
							continue;
						end
						i++;
					end
					if (n_entries >= TableDepth) begin
						push_report(KIND_REPLY, a, 0, 1); n++;
						idx = -2;
					end else begin
						idx = n_entries++;
						tbl[idx] = '{key: a, last_active: now_sec, open_count: 0,
							logged: 0, report: RPT_NONE};
					end
				end
				if (idx >= 0) begin
					if (tbl[idx].open_count == 0) begin
						tbl[idx].logged = 0;
						tbl[idx].report = RPT_NONE;
					end
					if (tbl[idx].open_count != CountMax) tbl[idx].open_count++;
					tbl[idx].last_active = now_sec;
					if (!tbl[idx].logged) begin
						tbl[idx].logged = 1; nc = 1;
					end
					push_report(KIND_REPLY, a, nc, 0); n++;
				end
			end
			CMD_DISCONNECT: begin
				idx = find_client(a);
				if (idx >= 0 && tbl[idx].open_count != 0) begin
					tbl[idx].open_count--;
					tbl[idx].last_active = now_sec;
					if (tbl[idx].open_count == 0 && tbl[idx].report == RPT_NONE) begin
						tbl[idx].report = KIND_DISC;
						push_report(KIND_DISC, a, 0, 0); n++;
					end
				end
			end
			CMD_TICK: begin
				now_sec++;
				for (i = 0; i < n_entries && n < MaxResults; i++)
					if (tbl[i].open_count == 0 && tbl[i].report == RPT_NONE &&
						(now_sec - tbl[i].last_active) >= {16'd0, timeout_sec}) begin
						tbl[i].report = KIND_TIMEOUT;
						push_report(KIND_TIMEOUT, tbl[i].key, 0, 0); n++;
					end
			end
			default: begin
				for (i = 0; i < n_entries && n < MaxResults; i++)
					if (tbl[i].open_count != 0) begin
						tbl[i].report = KIND_SHUT;
						push_report(KIND_SHUT, tbl[i].key, 0, 0); n++;
					end else if (tbl[i].report == RPT_NONE) begin
						tbl[i].report = KIND_TIMEOUT;
						push_report(KIND_TIMEOUT, tbl[i].key, 0, 0); n++;
					end
			end
		endcase
		if (n > 0) expected_reports[base+n-1].last = 1'b1;
	endfunction

	// output checker
	always @(posedge clk) begin
		result_t got, exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.addr = m_axis_tdata[31:0];
			got.newc = m_axis_tdata[32];
			got.full = m_axis_tdata[33];
			got.last = m_axis_tlast;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected report %p", got);
			end else begin
				exp_r = expected_reports.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) $display("report mismatch exp %p got %p", exp_r, got);
				end
			end
		end
	end

	// sink readiness
	always @(posedge clk)
		m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);

	task automatic send_request(logic [1:0] cmd, logic [31:0] a);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tuser <= cmd;
		s_axis_tdata <= a;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		track_request(cmd, a);
	endtask

	task automatic drain();
		int guard;
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (expected_reports.size() != 0 && guard < 200000) begin
			@(posedge clk); guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_timeout(logic [15:0] v);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		timeout_sec = v;
		@(posedge clk);
	endtask

	typedef struct {
		logic [1:0] cmd;
		logic [31:0] a;
	} stim_t;

	// pool of addresses keeps hits frequent
	logic [31:0] pool[16];

	task automatic random_phase(int cnt);
		int r;
		logic [31:0] a;
		for (int i = 0; i < cnt; i++) begin
			r = $urandom_range(99);
			a = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(15)];
			if (r < 40) send_request(CMD_CONNECT, a);
			else if (r < 70) send_request(CMD_DISCONNECT, a);
			else if (r < 97) send_request(CMD_TICK, $urandom);
			else send_request(CMD_FLUSH, $urandom);
		end
	endtask

	initial begin
		stim_t dir[$];
		mismatches = 0;
		n_entries = 0; now_sec = '0; timeout_sec = TimeoutReset;
		hold_sink = 0; src_idle_pct = 35; snk_idle_pct = 69;
		for (int i = 0; i < 16; i++) pool[i] = $urandom;
		pool[0] = 32'h0000_0000; pool[1] = 32'hFFFF_FFFF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first connect, reconnect, disconnects, unknown disconnect, timeout,
		// flush; then a connect that sweeps out expired clients, and a flush
		dir = '{'{CMD_CONNECT, 32'h0}, '{CMD_CONNECT, 32'h0}, '{CMD_CONNECT, 32'hFFFF_FFFF},
			'{CMD_DISCONNECT, 32'h0}, '{CMD_DISCONNECT, 32'h0}, '{CMD_DISCONNECT, 32'h0},
			'{CMD_DISCONNECT, 32'h1234_5678}, '{CMD_TICK, 32'h0}, '{CMD_FLUSH, 32'h0}};
		for (int i = 0; i < 11; i++) dir.push_back('{CMD_TICK, 32'hFFFF_FFFF});
		dir.push_back('{CMD_CONNECT, 32'hAAAA_5555});
		dir.push_back('{CMD_FLUSH, 32'hFFFF_FFFF});
		foreach (dir[i]) send_request(dir[i].cmd, dir[i].a);
		drain();

		// fill table past its depth with long-lived clients
		write_timeout(16'hFFFF);
		for (int i = 0; i < TableDepth + 2; i++) send_request(CMD_CONNECT, 32'h1000_0000 + i);
		drain();
		// long receiver stall while requests keep coming
		hold_sink = 1;
		fork
			begin repeat (400) @(posedge clk); hold_sink = 0; end
			begin send_request(CMD_FLUSH, '0); send_request(CMD_FLUSH, '0);
				send_request(CMD_TICK, '0); end
		join
		drain();

		write_timeout(16'd1);
		random_phase(40);
		drain();
		write_timeout(16'd0);
		random_phase(30);
		drain();
		src_idle_pct = 69; snk_idle_pct = 35;
		write_timeout(16'd3);
		random_phase(80);
		drain();
		src_idle_pct = 0; snk_idle_pct = 0;
		write_timeout(16'd5);
		random_phase(101);
		drain();

		if (mismatches == 0 && expected_reports.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end
endmodule
